/* src/generational_handle_table_assert.svh */
// ---------------------------------------------------------------------------
// Generational handle table assertion macros
// Concurrent assertion wrappers that compile away in synthesis.
// ---------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_TABLE_ASSERT_SVH
`define GENERATIONAL_HANDLE_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define GHT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("generational handle table assertion failed");
`define GHT_ASSERT_RESET(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("generational handle table reset assertion failed");
`else
`define GHT_ASSERT(lbl, prop)
`define GHT_ASSERT_RESET(lbl, prop)
`endif
`endif

/* src/ght_pkg.sv */
// ---------------------------------------------------------------------------
// Generational handle table package
// Item types, request and status codes, and controller commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ght_pkg;

  localparam int IDX_W      = 12;
  localparam int SLOT_COUNT = 1 << IDX_W;
  localparam int GEN_W      = 15;
  localparam int KIND_W     = 5;
  localparam int PAY_W      = 32;
  localparam int REQ_W      = 2;
  localparam int STAT_W     = 2;

  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);

  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_GET    = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_STALE = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [IDX_W-1:0]  slot_index;
    logic [GEN_W-1:0]  generation;
    logic [KIND_W-1:0] kind_tag;
    logic [PAY_W-1:0]  payload;
  } ght_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  out_index;
    logic [GEN_W-1:0]  out_generation;
    logic [KIND_W-1:0] out_kind;
    logic [PAY_W-1:0]  out_payload;
  } ght_out_t;

  typedef struct packed {
    logic load;
    logic commit;
  } ght_cmd_t;

endpackage

/* src/ght_ctrl.sv */
// ---------------------------------------------------------------------------
// Generational handle table controller
// Two-state sequencer for the handshakes and the slot read-modify-write.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ght_ctrl
  import ght_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ght_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_ready   = (state_r == S_IDLE);
  assign cmd.load   = in_valid && in_ready;
  assign cmd.commit = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign out_valid  = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* src/ght_dp.sv */
// ---------------------------------------------------------------------------
// Generational handle table datapath
// Slot memory, free-list head, fill mark, live count and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "generational_handle_table_assert.svh"

module ght_dp
  import ght_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  ght_cmd_t cmd,
  input  ght_in_t  in_item,
  output ght_out_t out_item
);

  typedef struct packed {
    logic             active;
    logic [GEN_W-1:0] generation;
    logic [IDX_W-1:0] link;
    logic [PAY_W-1:0] payload;
  } ght_slot_t;

  // Slots at or above the fill mark have never been written and read as
  // their reset contents: inactive, counter zero, linked to the next slot.
  ght_slot_t        mem [SLOT_COUNT];
  ght_slot_t        rd_r;
  ght_in_t          req_r;
  ght_out_t         out_r, out_nxt;
  logic [IDX_W-1:0] free_head_r, free_head_nxt;
  logic [IDX_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0] live_r, live_nxt;

  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] slot_addr;
  logic             seen;
  logic             cur_active;
  logic [GEN_W-1:0] cur_gen;
  logic [IDX_W-1:0] cur_link;
  logic [GEN_W-1:0] bumped;
  logic             handle_ok;
  logic             wr_en;
  ght_slot_t        wr_data;

  assign rd_addr   = (in_item.req_type == REQ_ADD) ? free_head_r : in_item.slot_index;
  assign slot_addr = (req_r.req_type == REQ_ADD) ? free_head_r : req_r.slot_index;
  assign seen       = (slot_addr < fill_r);
  assign cur_active = seen && rd_r.active;
  assign cur_gen    = seen ? rd_r.generation : '0;
  assign cur_link   = seen ? rd_r.link : slot_addr + IDX_W'(1);
  assign handle_ok  = cur_active && (cur_gen == req_r.generation);

  always_comb begin
    bumped = cur_gen + GEN_W'(1);
    if (bumped == '0) begin
      bumped = GEN_W'(1);
    end
  end

  always_comb begin
    out_nxt       = '0;
    wr_en         = 1'b0;
    wr_data       = rd_r;
    free_head_nxt = free_head_r;
    fill_nxt      = fill_r;
    live_nxt      = live_r;
    unique case (req_r.req_type)
      REQ_ADD: begin
        if (live_r == LAST_SLOT) begin
          out_nxt.status = ST_FULL;
        end else begin
          wr_en                  = 1'b1;
          wr_data.active         = 1'b1;
          wr_data.generation     = bumped;
          wr_data.link           = '0;
          wr_data.payload        = req_r.payload;
          free_head_nxt          = cur_link;
          live_nxt               = live_r + IDX_W'(1);
          fill_nxt               = seen ? fill_r : fill_r + IDX_W'(1);
          out_nxt.out_index      = free_head_r;
          out_nxt.out_generation = bumped;
          out_nxt.out_kind       = req_r.kind_tag;
        end
      end
      REQ_UPDATE: begin
        if (!handle_ok) begin
          out_nxt.status = ST_STALE;
        end else begin
          wr_en           = 1'b1;
          wr_data.payload = req_r.payload;
        end
      end
      REQ_REMOVE: begin
        if (!handle_ok) begin
          out_nxt.status = ST_STALE;
        end else begin
          wr_en          = 1'b1;
          wr_data.active = 1'b0;
          wr_data.link   = free_head_r;
          free_head_nxt  = slot_addr;
          live_nxt       = live_r - IDX_W'(1);
        end
      end
      REQ_GET: begin
        if (!handle_ok) begin
          out_nxt.status = ST_STALE;
        end else begin
          out_nxt.out_payload = rd_r.payload;
        end
      end
      default: out_nxt.status = ST_STALE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_r  <= mem[rd_addr];
      req_r <= in_item;
    end
    if (cmd.commit && wr_en) begin
      mem[slot_addr] <= wr_data;
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      fill_r      <= '0;
      live_r      <= '0;
    end else if (cmd.commit) begin
      free_head_r <= free_head_nxt;
      fill_r      <= fill_nxt;
      live_r      <= live_nxt;
    end
  end

  assign out_item = out_r;

  `GHT_ASSERT(a_live_within_fill, live_r <= fill_r)
  `GHT_ASSERT(a_head_within_fill, free_head_r <= fill_r)
  `GHT_ASSERT(a_add_counts_up, cmd.commit && req_r.req_type == REQ_ADD && live_r != LAST_SLOT |=> live_r == $past(live_r) + IDX_W'(1))
  `GHT_ASSERT(a_add_gen_nonzero, cmd.commit && req_r.req_type == REQ_ADD && live_r != LAST_SLOT |=> out_r.out_generation != '0)
  `GHT_ASSERT_RESET(a_reset_clears, !rst_n |=> live_r == '0 && free_head_r == '0 && fill_r == '0)

endmodule

/* src/generational_handle_table.sv */
// ---------------------------------------------------------------------------
// Generational handle table
// Allocates, updates, removes and reads handles with generation counters
// over a free-listed slot memory.
// ---------------------------------------------------------------------------
// Channel   Direction  Item       Handshake
// in_       input      ght_in_t   in_valid / in_ready
// out_      output     ght_out_t  out_valid / out_ready
//
// Each item passes through two steps: a read of the slot memory, then a check,
// write back and load of the result register. The single-port slot memory
// sets this split. No clearing pass follows reset; a fill mark stands in for it.
// A new item is taken while a result waits; a stalled result holds the
// check and write-back of the next item until it is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module generational_handle_table
  import ght_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ght_in_t  in_item,
  output logic     out_valid,
  input  logic     out_ready,
  output ght_out_t out_item
);

  ght_cmd_t cmd;

  ght_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ght_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule
